[hw/rtl/crda_pkg.sv]
// Shared types, constants and the report layout map of the counter delta accumulator.
package crda_pkg;

   localparam int REPORT_WORDS  = 64;
   localparam int ACC_COUNT     = 62;
   localparam int WORD_W        = 32;
   localparam int ACC_W         = 64;
   localparam int WIDE_W        = 40;
   localparam int ADDR_W        = $clog2(REPORT_WORDS);
   localparam int ACC_IDX_W     = $clog2(ACC_COUNT);

   localparam int FIRST_WORD    = 1;
   localparam int LO_OFFSET     = 2;
   localparam int TAIL_OFFSET   = 10;
   localparam int HI_BASE       = 40;
   localparam int WIDE_FIRST    = 2;
   localparam int WIDE_LAST     = 33;
   localparam int TAIL_FIRST    = 38;
   localparam int RESULTS_MIXED = 54;
   localparam int RESULTS_FLAT  = 62;

   localparam logic MODE_MIXED = 1'b0;
   localparam logic MODE_FLAT  = 1'b1;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [ADDR_W-1:0]    word_addr_type;
   typedef logic [ACC_IDX_W-1:0] acc_idx_type;
   typedef logic [ACC_W-1:0]     acc_type;

   typedef struct packed {
      logic          en;
      word_addr_type lo_addr;
      word_addr_type hi_addr;
   } rd_req_type;

   typedef struct packed {
      logic          en;
      word_addr_type addr;
      word_type      data;
   } wr_req_type;

   typedef struct packed {
      word_type cur_lo;
      word_type cur_hi;
      word_type prev_lo;
      word_type prev_hi;
   } rd_data_type;

   typedef struct packed {
      word_addr_type lo_addr;
      word_addr_type hi_addr;
      logic          is_wide;
      logic [1:0]    byte_sel;
   } step_type;

   // Maps result number j of a sweep to the report words that feed it.
   function automatic step_type step_map(logic mode, acc_idx_type j);
      step_type    s;
      acc_idx_type i;
      i = j - ACC_IDX_W'(WIDE_FIRST);
      s.is_wide  = (mode == MODE_MIXED) && (j >= ACC_IDX_W'(WIDE_FIRST))
                   && (j <= ACC_IDX_W'(WIDE_LAST));
      s.hi_addr  = ADDR_W'(HI_BASE) + {3'b000, i[4:2]};
      s.byte_sel = i[1:0];
      if (j == '0) begin
         s.lo_addr = ADDR_W'(FIRST_WORD);
      end else if ((mode == MODE_MIXED) && (j >= ACC_IDX_W'(TAIL_FIRST))) begin
         s.lo_addr = ADDR_W'(j) + ADDR_W'(TAIL_OFFSET);
      end else begin
         s.lo_addr = ADDR_W'(j) + ADDR_W'(LO_OFFSET);
      end
      return s;
   endfunction

endpackage

[hw/rtl/crda_report_store.sv]
// Current and previous report memories with two registered read ports each.
module crda_report_store (
   input  logic                     clock,
   input  crda_pkg::wr_req_type     cur_wr,
   input  crda_pkg::wr_req_type     prev_wr,
   input  crda_pkg::rd_req_type     rd,
   output crda_pkg::rd_data_type    rd_data
);
   import crda_pkg::*;

   word_type    cur_mem_ff  [REPORT_WORDS];
   word_type    prev_mem_ff [REPORT_WORDS];
   rd_data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cur_wr.en) begin
         cur_mem_ff[cur_wr.addr] <= cur_wr.data;
      end
      if (prev_wr.en) begin
         prev_mem_ff[prev_wr.addr] <= prev_wr.data;
      end
      if (rd.en) begin
         rd_data_ff.cur_lo  <= cur_mem_ff[rd.lo_addr];
         rd_data_ff.cur_hi  <= cur_mem_ff[rd.hi_addr];
         rd_data_ff.prev_lo <= prev_mem_ff[rd.lo_addr];
         rd_data_ff.prev_hi <= prev_mem_ff[rd.hi_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/counter_report_delta_accumulator.sv]
// Top level of the counter report delta accumulator.
//
// Reports of 64 counter words come in on the req_ channel, one word per item,
// each tagged with its position and an end-of-report flag. Words are taken
// one per cycle while the block is idle. When the end-of-report word arrives
// after an earlier complete report, the block sweeps the accumulators: it
// emits 54 results in mixed layout or 62 in flat layout on the rsp_ channel,
// one per cycle while rsp_ does not stall, each passing the read stage, the
// delta stage and the output register. Each result carries the updated
// 64-bit accumulator, and the last result of a report is flagged. The sweep
// then copies the current report into the previous report memory, one word
// per cycle once the sweep reads have drained, all 64 words; the first report
// after reset only does this copy. The cost of a report is set by the single
// write port of each report memory and the one-result-per-cycle sweep.
// The layout register on the csr_ port must be written only while the block is
// idle; the block itself does not enforce this.
// A stall on rsp_ holds the whole sweep pipeline; a finished result waits in
// the output register. Reset clears the accumulators, the layout register
// and the priming flag; report words are undefined until written.
module counter_report_delta_accumulator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  crda_pkg::word_type     req_word_value,
   input  crda_pkg::word_addr_type req_word_index,
   input  logic                   req_end_of_report,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output crda_pkg::acc_idx_type  rsp_acc_index,
   output crda_pkg::acc_type      rsp_acc_value,
   output logic                   rsp_last_result,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_layout_mode
);
   import crda_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_COPY} state_type;

   state_type         state_ff, state_in;
   logic              mode_ff, mode_in;
   logic              have_prev_ff, have_prev_in;
   acc_idx_type       j_ff, j_in;
   word_addr_type     copy_cnt_ff, copy_cnt_in;
   logic              cw_vld_ff, cw_vld_in;
   word_addr_type     cw_addr_ff, cw_addr_in;

   logic              v1_ff, v1_in;
   acc_idx_type       idx1_ff, idx1_in;
   logic              last1_ff, last1_in;
   logic              wide1_ff, wide1_in;
   logic [1:0]        bsel1_ff, bsel1_in;

   logic              v2_ff, v2_in;
   acc_idx_type       idx2_ff, idx2_in;
   logic              last2_ff, last2_in;
   logic [WIDE_W-1:0] delta2_ff, delta2_in;
   acc_type           old2_ff, old2_in;

   logic              rsp_valid_ff, rsp_valid_in;
   acc_idx_type       rsp_idx_ff, rsp_idx_in;
   acc_type           rsp_val_ff, rsp_val_in;
   logic              rsp_last_ff, rsp_last_in;

   acc_type           acc_mem_ff [ACC_COUNT];
   logic              acc_vld_ff [ACC_COUNT];
   acc_type           acc_rd_ff;
   logic              acc_rd_vld_ff;

   logic              advance;
   logic              issue;
   logic              copy_rd;
   logic              last_step;
   logic              req_take;
   step_type          step;
   rd_req_type        rd;
   wr_req_type        cur_wr;
   wr_req_type        prev_wr;
   rd_data_type       rd_data;
   logic [WIDE_W-1:0] new_val;
   logic [WIDE_W-1:0] old_val;
   logic [WIDE_W-1:0] delta;
   acc_type           sum;

   crda_report_store u_store (
      .clock   (clock),
      .cur_wr  (cur_wr),
      .prev_wr (prev_wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = step_map(mode_ff, j_ff);
   assign last_step = (mode_ff == MODE_MIXED) ? (j_ff == ACC_IDX_W'(RESULTS_MIXED - 1))
                                              : (j_ff == ACC_IDX_W'(RESULTS_FLAT - 1));
   assign issue     = (state_ff == ST_SWEEP) && advance;
   assign copy_rd   = (state_ff == ST_COPY) && !v1_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rd.en      = issue || copy_rd;
   assign rd.lo_addr = copy_rd ? copy_cnt_ff : step.lo_addr;
   assign rd.hi_addr = step.hi_addr;

   assign cur_wr.en    = req_take;
   assign cur_wr.addr  = req_word_index;
   assign cur_wr.data  = req_word_value;
   assign prev_wr.en   = cw_vld_ff;
   assign prev_wr.addr = cw_addr_ff;
   assign prev_wr.data = rd_data.cur_lo;

   always_comb begin
      if (wide1_ff) begin
         new_val = {8'(rd_data.cur_hi >> {bsel1_ff, 3'b000}), rd_data.cur_lo};
         old_val = {8'(rd_data.prev_hi >> {bsel1_ff, 3'b000}), rd_data.prev_lo};
      end else begin
         new_val = {8'h00, rd_data.cur_lo};
         old_val = {8'h00, rd_data.prev_lo};
      end
      delta = new_val - old_val;
      if (!wide1_ff) begin
         delta[WIDE_W-1:WORD_W] = '0;
      end
   end

   assign sum = old2_ff + {{(ACC_W - WIDE_W){1'b0}}, delta2_ff};

   always_comb begin
      state_in     = state_ff;
      mode_in      = csr_valid ? csr_layout_mode : mode_ff;
      have_prev_in = have_prev_ff;
      j_in         = j_ff;
      copy_cnt_in  = copy_cnt_ff;
      cw_vld_in    = copy_rd;
      cw_addr_in   = copy_cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_end_of_report) begin
               have_prev_in = 1'b1;
               j_in         = '0;
               copy_cnt_in  = '0;
               state_in     = have_prev_ff ? ST_SWEEP : ST_COPY;
            end
         end
         ST_SWEEP: begin
            if (issue) begin
               j_in = j_ff + 1'b1;
               if (last_step) begin
                  state_in = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            if (copy_rd) begin
               copy_cnt_in = copy_cnt_ff + 1'b1;
               if (copy_cnt_ff == ADDR_W'(REPORT_WORDS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      v1_in    = advance ? issue : v1_ff;
      idx1_in  = issue ? j_ff : idx1_ff;
      last1_in = issue ? last_step : last1_ff;
      wide1_in = issue ? step.is_wide : wide1_ff;
      bsel1_in = issue ? step.byte_sel : bsel1_ff;

      v2_in     = advance ? v1_ff : v2_ff;
      idx2_in   = idx2_ff;
      last2_in  = last2_ff;
      delta2_in = delta2_ff;
      old2_in   = old2_ff;
      if (advance && v1_ff) begin
         idx2_in   = idx1_ff;
         last2_in  = last1_ff;
         delta2_in = delta;
         old2_in   = acc_rd_vld_ff ? acc_rd_ff : '0;
      end

      rsp_valid_in = advance ? v2_ff : rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance && v2_ff) begin
         rsp_idx_in  = idx2_ff;
         rsp_val_in  = sum;
         rsp_last_in = last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_MIXED;
         have_prev_ff <= 1'b0;
         cw_vld_ff    <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         have_prev_ff <= have_prev_in;
         cw_vld_ff    <= cw_vld_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      j_ff        <= j_in;
      copy_cnt_ff <= copy_cnt_in;
      cw_addr_ff  <= cw_addr_in;
      idx1_ff     <= idx1_in;
      last1_ff    <= last1_in;
      wide1_ff    <= wide1_in;
      bsel1_ff    <= bsel1_in;
      idx2_ff     <= idx2_in;
      last2_ff    <= last2_in;
      delta2_ff   <= delta2_in;
      old2_ff     <= old2_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (advance && v2_ff) begin
         acc_mem_ff[idx2_ff] <= sum;
      end
      if (issue) begin
         acc_rd_ff <= acc_mem_ff[j_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ACC_COUNT; k++) begin
            acc_vld_ff[k] <= 1'b0;
         end
         acc_rd_vld_ff <= 1'b0;
      end else begin
         if (advance && v2_ff) begin
            acc_vld_ff[idx2_ff] <= 1'b1;
         end
         if (issue) begin
            acc_rd_vld_ff <= acc_vld_ff[j_ff];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_acc_index   = rsp_idx_ff;
   assign rsp_acc_value   = rsp_val_ff;
   assign rsp_last_result = rsp_last_ff;

   a_last_index : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |->
         (rsp_idx_ff == ACC_IDX_W'(RESULTS_MIXED - 1))
         || (rsp_idx_ff == ACC_IDX_W'(RESULTS_FLAT - 1)))
      else $error("last result flag on a non-final accumulator");

   a_acc_range : assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> idx2_ff < ACC_IDX_W'(ACC_COUNT))
      else $error("accumulator index out of range");

   a_copy_port : assert property (@(posedge clock) disable iff (reset)
      copy_rd |-> !issue && !v1_ff)
      else $error("copy read collides with a sweep read");

   a_take_drained : assert property (@(posedge clock) disable iff (reset)
      req_take |-> !v1_ff && (state_ff == ST_IDLE))
      else $error("item taken while the sweep still reads");

endmodule
